[rtl/core/atgf_pkg.sv]
// Shared constants and register codes for the audio trim/gain/fade block.
package atgf_pkg;

  // default sizes for the top-level parameters
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COUNT_BITS_DEF     = 32;
  localparam int FADE_FRAC_BITS_DEF = 16;

  // fixed register layout
  localparam int REG_BITS     = 32;
  localparam int GAIN_BITS    = 16;
  localparam int GAIN_FRAC    = 13;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [REG_BITS-1:0]  TRIM_END_RESET = 32'hFFFF_FFFF;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET     = 16'd8192;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TRIM_START   = 3'd0,
    CFG_TRIM_END     = 3'd1,
    CFG_GAIN         = 3'd2,
    CFG_FADE_IN_LEN  = 3'd3,
    CFG_FADE_OUT_LEN = 3'd4
  } cfg_reg_t;

endpackage

[rtl/core/atgf_in_if.sv]
// Input sample channel: valid/ready with one decoded sample per request.
interface atgf_in_if
  import atgf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          channel_start;

  modport source (output valid, sample_in, channel_start, input ready);
  modport sink   (input valid, sample_in, channel_start, output ready);
endinterface

[rtl/core/atgf_out_if.sv]
// Output sample channel: valid/ready with one processed sample per request.
interface atgf_out_if
  import atgf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last_kept;

  modport source (output valid, sample_out, last_kept, input ready);
  modport sink   (input valid, sample_out, last_kept, output ready);
endinterface

[rtl/core/atgf_ser_mul.sv]
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
module atgf_ser_mul
  import atgf_pkg::*;
#(
  parameter int A_BITS = GAIN_BITS,
  parameter int B_BITS = GAIN_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic                     busy,
  output logic [A_BITS+B_BITS-1:0] prod
);
  localparam int CNT_BITS = $clog2(B_BITS + 1);

  logic [A_BITS-1:0]   mcand;
  logic [B_BITS-1:0]   mplier;
  logic [CNT_BITS-1:0] count;
  logic [A_BITS:0]     partial;

  // upper half plus the selected multiplicand; low half shifts out
  assign partial = (A_BITS+1)'(prod[A_BITS+B_BITS-1 -: A_BITS])
                 + (A_BITS+1)'(mplier[0] ? mcand : {A_BITS{1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      count  <= CNT_BITS'(B_BITS);
      prod   <= '0;
      mcand  <= a;
      mplier <= b;
    end else if (busy) begin
      prod   <= {partial, prod[B_BITS-1:1]};
      mplier <= mplier >> 1;
      count  <= count - 1'b1;
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

[rtl/core/atgf_ser_div.sv]
// Restoring divider for ramp factors: floor(num * 2^Q_BITS / den) for num < den, else exactly one; one bit per cycle.
module atgf_ser_div
  import atgf_pkg::*;
#(
  parameter int DEN_BITS = REG_BITS,
  parameter int Q_BITS   = FADE_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DEN_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                busy,
  output logic [Q_BITS:0]     quo
);
  localparam int CNT_BITS = $clog2(Q_BITS + 1);

  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] dvsr;
  logic [CNT_BITS-1:0] count;
  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS:0]   diff;
  logic                take;

  // remainder stays below the divisor, so a clear top bit means no borrow
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dvsr};
  assign take    = !diff[DEN_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      if (num >= den) begin
        // full ramp: exactly one
        quo <= {1'b1, {Q_BITS{1'b0}}};
      end else begin
        busy  <= 1'b1;
        count <= CNT_BITS'(Q_BITS);
        rem   <= num;
        dvsr  <= den;
        quo   <= '0;
      end
    end else if (busy) begin
      rem   <= take ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
      quo   <= {quo[Q_BITS-1:0], take};
      count <= count - 1'b1;
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

[rtl/core/audio_trim_gain_fade.sv]
// Trim, gain and linear fade-in/out of one audio channel, bit-serial datapath.
// Kept sample (F = FADE_FRAC_BITS): gain multiply and ramp dividers, fade-in * fade-out
// when both fades are on, final multiply and clamp; a dropped sample frees the input with
// no result. A request is taken only in idle; the pace is set by the 16-step gain multiply
// and the F+1-step serial multiplies. A stalled result holds the next one at its last step.
// Reset (synchronous, active high): index 0, keep window all, unity gain, fades off.
module audio_trim_gain_fade
  import atgf_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF,
  parameter int FADE_FRAC_BITS = FADE_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  atgf_in_if.sink                 in_ch,
  atgf_out_if.source              out_ch,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_data
);
  localparam int S        = SAMPLE_BITS;
  localparam int F        = FADE_FRAC_BITS;
  localparam int CMP_BITS = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
  localparam int GP_BITS  = S + GAIN_BITS;      // |sample| * gain
  localparam int GM_BITS  = S + 3;              // |gained sample|, up to 2^(S+2)
  localparam int F1_BITS  = F + 1;              // fade factor, 2^F is one
  localparam int OP_BITS  = GM_BITS + F1_BITS;  // |gained| * fade
  localparam int VM_BITS  = S + 3;              // |result| before clamp

  localparam logic [GP_BITS:0]    GAIN_ROUND = (GP_BITS+1)'((64'd1 << GAIN_FRAC) - 1);
  localparam logic [OP_BITS:0]    FADE_ROUND = (OP_BITS+1)'((64'd1 << F) - 1);
  localparam logic [F:0]          FADE_ONE   = {1'b1, {F{1'b0}}};
  localparam logic [VM_BITS-1:0]  MAG_POS    = VM_BITS'((64'd1 << (S - 1)) - 1);
  localparam logic [VM_BITS-1:0]  MAG_NEG    = VM_BITS'(64'd1 << (S - 1));
  localparam logic [S-1:0]        SAT_MAX    = {1'b0, {(S-1){1'b1}}};
  localparam logic [S-1:0]        SAT_MIN    = {1'b1, {(S-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,   // window compares
    ST_SETUP,   // fade ranges
    ST_START,   // kick gain multiply and both ramp dividers
    ST_WAIT1,
    ST_COMB,    // round gain product, pick or combine fade factors
    ST_WAIT2,   // fade-in * fade-out
    ST_SCALE,   // kick final multiply
    ST_WAIT3,
    ST_FINISH   // clamp and hand to output register
  } state_t;

  // configuration
  logic [REG_BITS-1:0]  trim_start;
  logic [REG_BITS-1:0]  trim_end;
  logic [GAIN_BITS-1:0] gain_q;
  logic [REG_BITS-1:0]  fade_in_len;
  logic [REG_BITS-1:0]  fade_out_len;

  state_t                state;
  logic [COUNT_BITS-1:0] sample_index;
  logic [COUNT_BITS-1:0] idx;
  logic [COUNT_BITS-1:0] idx_next;
  logic [S-1:0]          smag;
  logic                  neg;
  logic                  keep;
  logic                  last;
  logic [REG_BITS-1:0]   ofs;       // position inside the kept window
  logic [REG_BITS-1:0]   span;      // kept window length
  logic [REG_BITS-1:0]   fo_num;
  logic                  fi_on;
  logic                  fo_on;
  logic [GM_BITS-1:0]    gmag;
  logic [F:0]            fade;
  logic [VM_BITS-1:0]    vmag;

  logic                  out_valid;
  logic [S-1:0]          out_sample;
  logic                  out_last;

  logic [CMP_BITS-1:0]   idx_ext;
  logic [CMP_BITS-1:0]   ts_ext;
  logic [CMP_BITS-1:0]   te_ext;
  logic                  in_req;

  // serial units
  logic                  gain_busy;
  logic [GP_BITS-1:0]    gprod;
  logic [GP_BITS:0]      gceil;
  logic                  fi_busy;
  logic [F:0]            fi_q;
  logic                  fo_busy;
  logic [F:0]            fo_q;
  logic                  fmul_start;
  logic                  fmul_busy;
  logic [2*F1_BITS-1:0]  fprod;
  logic                  omul_busy;
  logic [OP_BITS-1:0]    oprod;
  logic [OP_BITS:0]      oceil;
  logic                  out_free;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_req      = in_ch.valid && (state == ST_IDLE);
  assign idx_next    = in_ch.channel_start ? '0 : sample_index;

  assign idx_ext = CMP_BITS'(idx);
  assign ts_ext  = CMP_BITS'(trim_start);
  assign te_ext  = CMP_BITS'(trim_end);

  // negative values round toward minus infinity: ceiling of the magnitude
  assign gceil = (GP_BITS+1)'(gprod) + GAIN_ROUND;
  assign oceil = (OP_BITS+1)'(oprod) + FADE_ROUND;

  assign fmul_start = (state == ST_COMB) && fi_on && fo_on;
  assign out_free   = !out_valid || out_ch.ready;

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.last_kept  = out_last;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_start   <= '0;
      trim_end     <= TRIM_END_RESET;
      gain_q       <= GAIN_RESET;
      fade_in_len  <= '0;
      fade_out_len <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TRIM_START:   trim_start   <= cfg_data;
        CFG_TRIM_END:     trim_end     <= cfg_data;
        CFG_GAIN:         gain_q       <= cfg_data[GAIN_BITS-1:0];
        CFG_FADE_IN_LEN:  fade_in_len  <= cfg_data;
        CFG_FADE_OUT_LEN: fade_out_len <= cfg_data;
        default: ;
      endcase
    end
  end

  atgf_ser_mul #(.A_BITS(S), .B_BITS(GAIN_BITS)) u_gain_mul (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_START),
    .a     (smag),
    .b     (gain_q),
    .busy  (gain_busy),
    .prod  (gprod)
  );

  atgf_ser_div #(.DEN_BITS(REG_BITS), .Q_BITS(F)) u_fi_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_START),
    .num   (ofs),
    .den   (fade_in_len),
    .busy  (fi_busy),
    .quo   (fi_q)
  );

  atgf_ser_div #(.DEN_BITS(REG_BITS), .Q_BITS(F)) u_fo_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_START),
    .num   (fo_num),
    .den   (fade_out_len),
    .busy  (fo_busy),
    .quo   (fo_q)
  );

  atgf_ser_mul #(.A_BITS(F1_BITS), .B_BITS(F1_BITS)) u_fade_mul (
    .clk   (clk),
    .rst   (rst),
    .start (fmul_start),
    .a     (fi_q),
    .b     (fo_q),
    .busy  (fmul_busy),
    .prod  (fprod)
  );

  atgf_ser_mul #(.A_BITS(GM_BITS), .B_BITS(F1_BITS)) u_out_mul (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_SCALE),
    .a     (gmag),
    .b     (fade),
    .busy  (omul_busy),
    .prod  (oprod)
  );

  // sequencer, running index and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_index <= '0;
      out_valid    <= 1'b0;
    end else begin
      // output register: load from the last step, else clear once taken
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_req) begin
            idx  <= idx_next;
            neg  <= in_ch.sample_in[S-1];
            smag <= in_ch.sample_in[S-1] ? (~in_ch.sample_in + 1'b1) : in_ch.sample_in;
            // index saturates at full scale
            sample_index <= (idx_next == {COUNT_BITS{1'b1}}) ? idx_next
                                                            : idx_next + 1'b1;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          keep  <= (idx_ext >= ts_ext) && (idx_ext < te_ext);
          last  <= ((CMP_BITS+1)'(idx) + 1'b1) == (CMP_BITS+1)'(trim_end);
          ofs   <= REG_BITS'(idx_ext - ts_ext);
          span  <= trim_end - trim_start;
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          fi_on  <= (fade_in_len != '0) && (ofs < fade_in_len);
          fo_on  <= (fade_out_len != '0) &&
                    (({1'b0, ofs} + {1'b0, fade_out_len}) >= {1'b0, span});
          fo_num <= span - ofs;
          state  <= keep ? ST_START : ST_IDLE;
        end
        ST_START: begin
          state <= ST_WAIT1;
        end
        ST_WAIT1: begin
          if (!gain_busy && !fi_busy && !fo_busy) begin
            state <= ST_COMB;
          end
        end
        ST_COMB: begin
          gmag <= neg ? gceil[GAIN_FRAC +: GM_BITS] : gprod[GAIN_FRAC +: GM_BITS];
          if (fi_on && fo_on) begin
            state <= ST_WAIT2;
          end else begin
            fade  <= fi_on ? fi_q : (fo_on ? fo_q : FADE_ONE);
            state <= ST_SCALE;
          end
        end
        ST_WAIT2: begin
          if (!fmul_busy) begin
            fade  <= fprod[F +: F1_BITS];
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_WAIT3;
        end
        ST_WAIT3: begin
          if (!omul_busy) begin
            vmag  <= neg ? oceil[F +: VM_BITS] : oprod[F +: VM_BITS];
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // wait for room in the output register, then clamp
          if (out_free) begin
            out_last  <= last;
            if (neg) begin
              out_sample <= (vmag > MAG_NEG) ? SAT_MIN : S'(~vmag + 1'b1);
            end else begin
              out_sample <= (vmag > MAG_POS) ? SAT_MAX : vmag[S-1:0];
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
